// File: design/swfr_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and register map of the stop-and-wait frame receiver.
package swfr_pkg;

	localparam int unsigned MAX_PAYLOAD = 2048;
	// byte counter saturates at MAX_PAYLOAD + 2
	localparam int unsigned CNT_W = $clog2(MAX_PAYLOAD + 3);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PAYLOAD);
	localparam logic [CNT_W-1:0] CNT_LONG = CNT_W'(MAX_PAYLOAD + 1);
	localparam logic [CNT_W-1:0] CNT_SAT = CNT_W'(MAX_PAYLOAD + 2);
	localparam logic [CNT_W-1:0] CNT_MIN = CNT_W'(2);
	localparam int unsigned LEN_W = 12;

	// command queue, depth a power of two
	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QIDX_W = $clog2(QDEPTH);

	localparam logic [7:0] CTRL_SEQ0 = 8'h00;
	localparam logic [7:0] CTRL_SEQ1 = 8'h40;
	localparam logic [7:0] STUFF_MASK = 8'h20;

	// position inside a reply frame
	localparam int unsigned POS_W = 3;
	localparam logic [POS_W-1:0] RB_OPEN = 3'd0;
	localparam logic [POS_W-1:0] RB_ADDR = 3'd1;
	localparam logic [POS_W-1:0] RB_CTRL = 3'd2;
	localparam logic [POS_W-1:0] RB_CHECK = 3'd3;
	localparam logic [POS_W-1:0] RB_CLOSE = 3'd4;

	localparam int unsigned NUM_REGS = 7;
	localparam int unsigned PADDR_W = $clog2(NUM_REGS * 4);
	localparam int unsigned PDATA_W = 32;

	typedef enum logic [2:0] {
		REG_FLAG = 3'd0,
		REG_ESCAPE = 3'd1,
		REG_CMD_ADDR = 3'd2,
		REG_REPLY_ADDR = 3'd3,
		REG_DISCONNECT = 3'd4,
		REG_READY = 3'd5,
		REG_REJECT = 3'd6
	} reg_idx_t;

	typedef enum logic [2:0] {
		PH_HUNT,
		PH_FLAG,
		PH_ADDR,
		PH_CTRL,
		PH_DATA,
		PH_ESC
	} phase_t;

	typedef enum logic [2:0] {
		ST_ACCEPTED = 3'd0,
		ST_BAD_CHECK = 3'd1,
		ST_DUPLICATE = 3'd2,
		ST_DISCONNECT = 3'd3,
		ST_BAD_SIZE = 3'd4
	} status_t;

	typedef struct packed {
		logic [7:0] flag;
		logic [7:0] escape;
		logic [7:0] cmd_addr;
		logic [7:0] reply_addr;
		logic [7:0] disconnect;
		logic [6:0] ready;
		logic [6:0] reject;
	} cfg_t;

	// one queued request: a payload byte or a whole reply frame
	typedef struct packed {
		logic is_reply;
		logic [7:0] data;
		status_t status;
		logic [LEN_W-1:0] len;
	} cmd_t;

endpackage

// File: design/stop_wait_frame_receiver.sv
`timescale 1ns / 1ps
// Top level of the stop-and-wait frame receiver.
// Usage:
//   Raw line bytes enter on rx_byte with byte_valid; a byte is taken at a clock
//   edge where byte_valid is high and byte_stall is low. Results leave on the
//   result channel (kind, out_byte, last, frame_status, payload_length) with
//   result_valid and result_stall. Registers sit on the APB-style port at byte
//   address 4*i; write them only while the block is idle.
//   Payload bytes are forwarded one byte late, released by the next data byte,
//   via the request queue and the output register. A closing flag, duplicate
//   or disconnect control produces a five-byte reply, one byte per cycle while
//   result_stall is low. Input takes one byte per cycle while byte_stall is
//   low; the parser decides each byte in the cycle it is taken and a four-entry
//   request queue feeds the output sequencer, which drains one result per cycle
//   while result_stall is low. byte_stall rises only while that queue is full.
//   Reset: registers return to their default codes, the parser hunts for a
//   flag, the expected sequence is zero and the queue and output are empty.
//   A stalled result holds on the ports; requests pile up in the queue and
//   then input stalls.
module stop_wait_frame_receiver import swfr_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [PADDR_W-1:0] paddr,
	input logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic pready,
	input logic byte_valid,
	output logic byte_stall,
	input logic [7:0] rx_byte,
	output logic result_valid,
	input logic result_stall,
	output logic kind,
	output logic [7:0] out_byte,
	output logic last,
	output logic [2:0] frame_status,
	output logic [LEN_W-1:0] payload_length
);

	cfg_t cfg;
	cmd_t front_cmd, head;
	logic front_valid, take, push, pop, q_full, q_empty;

	assign byte_stall = q_full;
	assign take = byte_valid && !byte_stall;
	assign push = front_valid;

	swfr_regs u_regs (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.cfg(cfg)
	);

	swfr_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.take(take),
		.rx_byte(rx_byte),
		.cfg(cfg),
		.cmd_valid(front_valid),
		.cmd(front_cmd)
	);

	swfr_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.wdata(front_cmd),
		.pop(pop),
		.full(q_full),
		.empty(q_empty),
		.rdata(head)
	);

	swfr_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head(head),
		.empty(q_empty),
		.cfg(cfg),
		.pop(pop),
		.result_stall(result_stall),
		.result_valid(result_valid),
		.kind(kind),
		.out_byte(out_byte),
		.last(last),
		.frame_status(frame_status),
		.payload_length(payload_length)
	);

endmodule

// File: design/swfr_regs.sv
`timescale 1ns / 1ps
// Configuration register file behind the APB-style port.
module swfr_regs import swfr_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [PADDR_W-1:0] paddr,
	input logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic pready,
	output cfg_t cfg
);

	cfg_t cfg_q;
	reg_idx_t idx;
	logic wr_en;

	assign pready = 1'b1;
	assign idx = reg_idx_t'(paddr[PADDR_W-1:2]);
	assign wr_en = psel && penable && pwrite && pready;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.flag <= 8'h7E;
			cfg_q.escape <= 8'h7D;
			cfg_q.cmd_addr <= 8'h03;
			cfg_q.reply_addr <= 8'h01;
			cfg_q.disconnect <= 8'h0B;
			cfg_q.ready <= 7'h05;
			cfg_q.reject <= 7'h01;
		end else if (wr_en) begin
			unique case (idx)
				REG_FLAG: cfg_q.flag <= pwdata[7:0];
				REG_ESCAPE: cfg_q.escape <= pwdata[7:0];
				REG_CMD_ADDR: cfg_q.cmd_addr <= pwdata[7:0];
				REG_REPLY_ADDR: cfg_q.reply_addr <= pwdata[7:0];
				REG_DISCONNECT: cfg_q.disconnect <= pwdata[7:0];
				REG_READY: cfg_q.ready <= pwdata[6:0];
				REG_REJECT: cfg_q.reject <= pwdata[6:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (idx)
			REG_FLAG: prdata = PDATA_W'(cfg_q.flag);
			REG_ESCAPE: prdata = PDATA_W'(cfg_q.escape);
			REG_CMD_ADDR: prdata = PDATA_W'(cfg_q.cmd_addr);
			REG_REPLY_ADDR: prdata = PDATA_W'(cfg_q.reply_addr);
			REG_DISCONNECT: prdata = PDATA_W'(cfg_q.disconnect);
			REG_READY: prdata = PDATA_W'(cfg_q.ready);
			REG_REJECT: prdata = PDATA_W'(cfg_q.reject);
			default: prdata = '0;
		endcase
	end

endmodule

// File: design/swfr_front.sv
`timescale 1ns / 1ps
// Front end: header parser, destuffer, check and count, request generation.
module swfr_front import swfr_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic take,
	input logic [7:0] rx_byte,
	input cfg_t cfg,
	output logic cmd_valid,
	output cmd_t cmd
);

	phase_t phase_q, phase_d;
	logic seq_q;
	logic [7:0] held_q;
	logic held_valid_q;
	logic [7:0] check_q;
	logic [CNT_W-1:0] count_q;
	logic [7:0] ctrl_q;

	logic is_flag, is_esc, is_ctrl, is_dup, is_disc, hdr_ok;
	logic [7:0] data_byte;
	logic take_data, close, size_bad, good;

	assign is_flag = (rx_byte == cfg.flag);
	assign is_esc = (rx_byte == cfg.escape);
	assign is_ctrl = (rx_byte == CTRL_SEQ0) || (rx_byte == CTRL_SEQ1);
	assign is_dup = is_ctrl && (rx_byte[6] != seq_q);
	assign is_disc = !is_ctrl && !is_flag && (rx_byte == cfg.disconnect);
	assign hdr_ok = (rx_byte == (cfg.cmd_addr ^ ctrl_q));
	assign data_byte = (phase_q == PH_ESC) ? (rx_byte ^ STUFF_MASK) : rx_byte;
	assign take_data = take
		&& (((phase_q == PH_DATA) && !is_flag && !is_esc) || (phase_q == PH_ESC));
	assign close = take && (phase_q == PH_DATA) && is_flag;
	assign size_bad = (count_q < CNT_MIN) || (count_q > CNT_LONG);
	assign good = !size_bad && (check_q == 8'h00);

	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			PH_HUNT: if (is_flag) phase_d = PH_FLAG;
			PH_FLAG: begin
				if (rx_byte == cfg.cmd_addr) phase_d = PH_ADDR;
				else if (!is_flag) phase_d = PH_HUNT;
			end
			PH_ADDR: begin
				if (is_ctrl) phase_d = is_dup ? PH_HUNT : PH_CTRL;
				else if (is_flag) phase_d = PH_FLAG;
				else phase_d = PH_HUNT;
			end
			PH_CTRL: begin
				if (hdr_ok) phase_d = PH_DATA;
				else if (is_flag) phase_d = PH_FLAG;
				else phase_d = PH_HUNT;
			end
			PH_DATA: begin
				if (is_flag) phase_d = PH_HUNT;
				else if (is_esc) phase_d = PH_ESC;
			end
			PH_ESC: phase_d = PH_DATA;
			default: phase_d = PH_HUNT;
		endcase
	end

	always_comb begin
		cmd_valid = 1'b0;
		cmd = '0;
		cmd.status = ST_ACCEPTED;
		if (take) begin
			unique case (phase_q)
				PH_ADDR: begin
					if (is_dup) begin
						cmd_valid = 1'b1;
						cmd.is_reply = 1'b1;
						cmd.data = {seq_q, cfg.ready};
						cmd.status = ST_DUPLICATE;
					end else if (is_disc) begin
						cmd_valid = 1'b1;
						cmd.is_reply = 1'b1;
						cmd.data = cfg.disconnect;
						cmd.status = ST_DISCONNECT;
					end
				end
				PH_DATA, PH_ESC: begin
					if (close) begin
						cmd_valid = 1'b1;
						cmd.is_reply = 1'b1;
						if (size_bad) begin
							cmd.data = {seq_q, cfg.reject};
							cmd.status = ST_BAD_SIZE;
						end else if (check_q != 8'h00) begin
							cmd.data = {seq_q, cfg.reject};
							cmd.status = ST_BAD_CHECK;
						end else begin
							cmd.data = {~seq_q, cfg.ready};
							cmd.status = ST_ACCEPTED;
							cmd.len = LEN_W'(count_q - CNT_W'(1));
						end
					end else if (take_data && held_valid_q && (count_q <= CNT_MAX)) begin
						// forward the byte held back one step
						cmd_valid = 1'b1;
						cmd.data = held_q;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			seq_q <= 1'b0;
			held_q <= '0;
			held_valid_q <= 1'b0;
			check_q <= '0;
			count_q <= '0;
			ctrl_q <= '0;
		end else if (take) begin
			phase_q <= phase_d;
			if ((phase_q == PH_ADDR) && is_ctrl) ctrl_q <= rx_byte;
			if ((phase_q == PH_CTRL) && hdr_ok) begin
				check_q <= '0;
				count_q <= '0;
				held_valid_q <= 1'b0;
				held_q <= '0;
			end
			if (take_data) begin
				check_q <= check_q ^ data_byte;
				held_q <= data_byte;
				held_valid_q <= 1'b1;
				if (count_q < CNT_SAT) count_q <= count_q + CNT_W'(1);
			end
			if (close && good) seq_q <= ~seq_q;
		end
	end

endmodule

// File: design/swfr_queue.sv
`timescale 1ns / 1ps
// Short request queue between the parser and the output sequencer.
module swfr_queue import swfr_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic push,
	input cmd_t wdata,
	input logic pop,
	output logic full,
	output logic empty,
	output cmd_t rdata
);

	cmd_t mem_q [QDEPTH];
	logic [QIDX_W-1:0] wr_q, rd_q;
	logic [QIDX_W:0] cnt_q;

	assign full = (cnt_q == (QIDX_W + 1)'(QDEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + QIDX_W'(1);
			if (pop) rd_q <= rd_q + QIDX_W'(1);
			if (push && !pop) cnt_q <= cnt_q + (QIDX_W + 1)'(1);
			else if (pop && !push) cnt_q <= cnt_q - (QIDX_W + 1)'(1);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("request pushed into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("request popped from empty queue");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (QIDX_W + 1)'(QDEPTH))
		else $error("queue fill count out of range");

endmodule

// File: design/swfr_back.sv
`timescale 1ns / 1ps
// Back end: expands requests into result bytes and holds the output register.
module swfr_back import swfr_pkg::*; (
	input logic clk,
	input logic arst_n,
	input cmd_t head,
	input logic empty,
	input cfg_t cfg,
	output logic pop,
	input logic result_stall,
	output logic result_valid,
	output logic kind,
	output logic [7:0] out_byte,
	output logic last,
	output logic [2:0] frame_status,
	output logic [LEN_W-1:0] payload_length
);

	logic [POS_W-1:0] pos_q;
	logic valid_q;
	logic kind_q, last_q;
	logic [7:0] byte_q;
	logic [2:0] status_q;
	logic [LEN_W-1:0] len_q;

	logic load, issue, at_close;
	logic [7:0] reply_byte;

	assign load = !valid_q || !result_stall;
	assign issue = load && !empty;
	assign at_close = (pos_q == RB_CLOSE);
	assign pop = issue && (!head.is_reply || at_close);

	always_comb begin
		case (pos_q)
			RB_OPEN: reply_byte = cfg.flag;
			RB_ADDR: reply_byte = cfg.reply_addr;
			RB_CTRL: reply_byte = head.data;
			RB_CHECK: reply_byte = cfg.reply_addr ^ head.data;
			default: reply_byte = cfg.flag;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= RB_OPEN;
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= !empty;
			if (issue && head.is_reply) pos_q <= at_close ? RB_OPEN : pos_q + POS_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			kind_q <= head.is_reply;
			if (head.is_reply) begin
				byte_q <= reply_byte;
				last_q <= at_close;
				status_q <= at_close ? head.status : ST_ACCEPTED;
				len_q <= at_close ? head.len : '0;
			end else begin
				// hold payload byte, status fields stay zero
				byte_q <= head.data;
				last_q <= 1'b0;
				status_q <= ST_ACCEPTED;
				len_q <= '0;
			end
		end
	end

	assign result_valid = valid_q;
	assign kind = kind_q;
	assign out_byte = byte_q;
	assign last = last_q;
	assign frame_status = status_q;
	assign payload_length = len_q;

endmodule
